[rtl/core/assert_macros.svh]
// Assertion macros shared by the chopper core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same check, also active while reset is held.
`define MSC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/core/msc_pkg.sv]
// Package: constants, types and the current-target table of the chopper core.
`default_nettype none

package msc_pkg;

   localparam int TABLE_ENTRIES = 128;

   localparam logic [7:0] STEP_INCREMENT_RESET = 8'd16;
   localparam logic [7:0] COIL_B_OFFSET        = 8'h40;
   localparam logic signed [7:0] PENDING_MAX   = 8'sd127;
   localparam logic signed [7:0] PENDING_MIN   = -8'sd127;

   typedef logic [1:0] drive_type;
   localparam drive_type DRIVE_OFF     = 2'd0;
   localparam drive_type DRIVE_FORWARD = 2'd1;
   localparam drive_type DRIVE_REVERSE = 2'd2;

   typedef logic [7:0] level_table_type [0:127];

   localparam level_table_type HALF_SINE = '{
      8'd0,   8'd3,   8'd5,   8'd8,   8'd11,  8'd13,  8'd16,  8'd19,
      8'd21,  8'd24,  8'd26,  8'd29,  8'd32,  8'd34,  8'd37,  8'd39,
      8'd42,  8'd44,  8'd47,  8'd49,  8'd51,  8'd54,  8'd56,  8'd58,
      8'd61,  8'd63,  8'd65,  8'd67,  8'd69,  8'd71,  8'd73,  8'd75,
      8'd77,  8'd79,  8'd81,  8'd83,  8'd84,  8'd86,  8'd88,  8'd89,
      8'd91,  8'd92,  8'd93,  8'd95,  8'd96,  8'd97,  8'd98,  8'd100,
      8'd101, 8'd102, 8'd103, 8'd103, 8'd104, 8'd105, 8'd106, 8'd106,
      8'd107, 8'd107, 8'd108, 8'd108, 8'd108, 8'd109, 8'd109, 8'd109,
      8'd109, 8'd109, 8'd109, 8'd109, 8'd108, 8'd108, 8'd108, 8'd107,
      8'd107, 8'd106, 8'd106, 8'd105, 8'd104, 8'd103, 8'd103, 8'd102,
      8'd101, 8'd100, 8'd98,  8'd97,  8'd96,  8'd95,  8'd93,  8'd92,
      8'd91,  8'd89,  8'd88,  8'd86,  8'd84,  8'd83,  8'd81,  8'd79,
      8'd77,  8'd75,  8'd73,  8'd71,  8'd69,  8'd67,  8'd65,  8'd63,
      8'd61,  8'd58,  8'd56,  8'd54,  8'd51,  8'd49,  8'd47,  8'd44,
      8'd42,  8'd39,  8'd37,  8'd34,  8'd32,  8'd29,  8'd26,  8'd24,
      8'd21,  8'd19,  8'd16,  8'd13,  8'd11,  8'd8,   8'd5,   8'd3
   };

   // Quantize the 7-bit index to TABLE_ENTRIES levels, map back to the
   // lowest reference sample of that level. Evaluated at elaboration only.
   function automatic level_table_type build_levels();
      level_table_type t;
      int unsigned     pos;
      int unsigned     fine;
      for (int i = 0; i < 128; i++) begin
         pos  = (i * TABLE_ENTRIES) >> 7;
         fine = (pos * 128) / TABLE_ENTRIES;
         t[i] = HALF_SINE[fine[6:0]];
      end
      return t;
   endfunction

   localparam level_table_type LEVEL_TABLE = build_levels();

endpackage

`default_nettype wire

[rtl/core/msc_coil_drive.sv]
// One coil's table lookup and current compare.
`default_nettype none

module msc_coil_drive
   import msc_pkg::*;
(
   input  wire logic [7:0] phase,
   input  wire logic [7:0] sense,
   output drive_type       drive
);

   logic [7:0] target;

   assign target = LEVEL_TABLE[phase[6:0]];

   always_comb begin
      if (sense < target) begin
         drive = phase[7] ? DRIVE_FORWARD : DRIVE_REVERSE;
      end else begin
         drive = DRIVE_OFF;
      end
   end

endmodule

`default_nettype wire

[rtl/core/microstep_sine_chopper_core.sv]
// Top level: microstep sine-table current chopper for a two-coil stepper.
//
//   channel | dir | signals                        | word
//   --------+-----+--------------------------------+------------------------------
//   req     | in  | req_tvalid/tready/tdata[23:0]  | one control tick
//   rsp     | out | rsp_tvalid/tready/tdata[15:0]  | coil drives and phase
//   csr     | in  | csr_valid/ready/data[7:0]      | step_increment
//
// One word in, one word out; the result is registered. One tick per cycle sustained while rsp_tready is high.
// The phase/pending-step update is a feedback loop that closes through phase_ff and pending_ff.
// req_tready is high whenever the result register is empty or being drained.
// Reset: pending count and phase clear, step increment returns to 16, no result held.
// csr is always ready; write it only while the core is idle.
`default_nettype none

module microstep_sine_chopper_core
   import msc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [0] step_pulse, [1] step_direction, [9:2] sense_a, [17:10] sense_b, [23:18] zero
   input  wire logic [23:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] coil_a_drive, [3:2] coil_b_drive, [11:4] phase, [15:12] zero
   output logic [15:0]      rsp_tdata,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data
);

`include "assert_macros.svh"

   // unpack tick word
   logic       step_pulse;
   logic       step_direction;
   logic [7:0] sense_a;
   logic [7:0] sense_b;

   assign step_pulse     = req_tdata[0];
   assign step_direction = req_tdata[1];
   assign sense_a        = req_tdata[9:2];
   assign sense_b        = req_tdata[17:10];

   logic              req_accept;

   // state
   logic [7:0]        step_increment_ff;
   logic [7:0]        phase_ff,   phase_in;
   logic signed [7:0] pending_ff, pending_in;
   logic signed [7:0] pending_req;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   drive_type         coil_a_ff, coil_b_ff;
   logic [7:0]        rsp_phase_ff;
   drive_type         coil_a_drive, coil_b_drive;
   logic [7:0]        phase_b;

   // accepted tick that neither queues nor executes a step
   logic              idle_tick;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Pulse first (saturating at +/-127), then execute at most one pending step.
   always_comb begin
      pending_req = pending_ff;
      if (step_pulse) begin
         if (step_direction) begin
            if (pending_ff < PENDING_MAX) begin
               pending_req = pending_ff + 8'sd1;
            end
         end else begin
            if (pending_ff > PENDING_MIN) begin
               pending_req = pending_ff - 8'sd1;
            end
         end
      end

      phase_in   = phase_ff;
      pending_in = pending_req;
      if (pending_req > 8'sd0) begin
         phase_in   = phase_ff + step_increment_ff;
         pending_in = pending_req - 8'sd1;
      end else if (pending_req < 8'sd0) begin
         phase_in   = phase_ff - step_increment_ff;
         pending_in = pending_req + 8'sd1;
      end
   end

   // coil B leads by a quarter turn
   assign phase_b = phase_in + COIL_B_OFFSET;

   msc_coil_drive u_coil_a (
      .phase (phase_in),
      .sense (sense_a),
      .drive (coil_a_drive)
   );

   msc_coil_drive u_coil_b (
      .phase (phase_b),
      .sense (sense_b),
      .drive (coil_b_drive)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_increment_ff <= STEP_INCREMENT_RESET;
         phase_ff          <= '0;
         pending_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            step_increment_ff <= csr_data;
         end
         if (req_accept) begin
            phase_ff   <= phase_in;
            pending_ff <= pending_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: loaded on accept, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         coil_a_ff    <= coil_a_drive;
         coil_b_ff    <= coil_b_drive;
         rsp_phase_ff <= phase_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_phase_ff, coil_b_ff, coil_a_ff};

   assign idle_tick = req_accept && !step_pulse && (pending_ff == 8'sd0);

   // checks
   `MSC_ASSERT(a_pending_range, pending_ff != -8'sd128, "pending count out of range")
   `MSC_ASSERT(a_no_drive_code3, rsp_valid_ff |-> !(&coil_a_ff || &coil_b_ff), "bad drive code")
   `MSC_ASSERT(a_accept_gives_result, req_accept |=> rsp_valid_ff, "accepted tick lost")
   `MSC_ASSERT(a_idle_phase_holds, idle_tick |=> $stable(phase_ff), "phase moved while idle")

endmodule

`default_nettype wire
